// ===== sv/sliding_window_minimizer_core_defines.svh =====
// ---------------------------------------------------------------------------
// sliding window minimizer assertion macros
// shared concurrent check forms on i_clk, disabled while i_rst_n is low
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MINIMIZER_CORE_DEFINES_SVH
`define SLIDING_WINDOW_MINIMIZER_CORE_DEFINES_SVH

// same-cycle implication
`define SWM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/swm_pkg.sv =====
// ---------------------------------------------------------------------------
// swm_pkg
// types and constants shared by the minimizer cell row and its controller
// ---------------------------------------------------------------------------
package swm_pkg;

    localparam int CODE_W = 62;
    localparam int HASH_W = 64;
    localparam int POS_W  = 31;
    localparam int CFG_W  = 7;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd8;

    localparam int IN_TDATA_W  = 160;
    localparam int OUT_TDATA_W = 96;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [CODE_W-1:0] kmer;
        logic [POS_W-1:0]  pos;
    } t_entry;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_PUSH,
        CELL_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     full;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_EXPIRE,
        S_DEDUP,
        S_EMIT
    } t_state;

endpackage

// ===== sv/swm_cell.sv =====
// ---------------------------------------------------------------------------
// swm_cell
// one queue slot: holds an entry, empties on a clear, drops it when a smaller hash arrives,
// takes the new entry at the back edge, or shifts in its right neighbor
// ---------------------------------------------------------------------------
module swm_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  swm_pkg::t_cell_ctl i_ctl,
    input  swm_pkg::t_entry   i_new,
    input  logic              i_keep_prev,
    input  logic              i_right_valid,
    input  swm_pkg::t_entry   i_right,
    output logic              o_valid,
    output swm_pkg::t_entry   o_entry,
    output logic              o_keep
);
    import swm_pkg::*;

    logic   r_valid;
    logic   n_valid;
    t_entry r_entry;
    t_entry n_entry;
    logic   w_keep;

    assign w_keep = r_valid && (r_entry.hash <= i_new.hash);

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        unique case (i_ctl.op)
            CELL_HOLD: begin
            end
            CELL_CLEAR: begin
                n_valid = 1'b0;
            end
            CELL_PUSH: begin
                if (i_ctl.full) begin
                    n_valid = i_right_valid;
                    n_entry = i_right;
                end else if (!w_keep) begin
                    if (i_keep_prev) begin
                        n_valid = 1'b1;
                        n_entry = i_new;
                    end else begin
                        n_valid = 1'b0;
                    end
                end
            end
            CELL_SHIFT: begin
                n_valid = i_right_valid;
                n_entry = i_right;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;
    assign o_keep  = w_keep;

endmodule

// ===== sv/sliding_window_minimizer_core.sv =====
// ---------------------------------------------------------------------------
// sliding window minimizer core - monotone hash queue in a row of shift cells
// one item at a time: accept, push, shift out expired fronts, drop equal-hash
// fronts if any expired, then emit; front drops shift the row once a cycle
// sync reset empties the queue, clears emit history, window 8; no clearing pass
// ---------------------------------------------------------------------------
`include "sliding_window_minimizer_core_defines.svh"

module sliding_window_minimizer_core #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [swm_pkg::CFG_W-1:0]           i_cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // kmer_code [61:0], kmer_hash [125:62], kmer_pos [156:126], zero pad
    input  logic [swm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // seq_start [0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // min_kmer [61:0], min_pos [92:62], zero pad
    output logic [swm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import swm_pkg::*;

    localparam int QD    = MAX_WINDOW + 1;
    localparam int WW    = $clog2(MAX_WINDOW + 1);
    localparam int CW    = (WW > CFG_W) ? WW : CFG_W;
    localparam int SW    = POS_W + 1;
    localparam int OPAD  = OUT_TDATA_W - CODE_W - POS_W;
    localparam int K_LO  = 0;
    localparam int H_LO  = CODE_W;
    localparam int P_LO  = CODE_W + HASH_W;

    t_state            r_state;
    t_state            n_state;
    logic [CFG_W-1:0]  r_cfg;
    t_entry            r_item;
    logic              r_dropped;
    logic              r_emitted;
    logic [POS_W-1:0]  r_last_pos;
    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_kmer;
    logic [POS_W-1:0]  r_out_pos;

    t_cell_ctl         w_ctl;
    logic [QD-1:0]     w_valid;
    logic [QD-1:0]     w_keep;
    t_entry            w_entry [QD];
    logic              w_accept;
    logic              w_load_out;
    logic [CW-1:0]     w_cfg_ext;
    logic [CW-1:0]     w_win;
    logic              w_expired;

    assign w_cfg_ext = CW'(r_cfg);

    always_comb begin
        if (w_cfg_ext == '0) begin
            w_win = CW'(1);
        end else if (w_cfg_ext > CW'(MAX_WINDOW)) begin
            w_win = CW'(MAX_WINDOW);
        end else begin
            w_win = w_cfg_ext;
        end
    end

    // front position <= new position - window
    assign w_expired = (SW'(w_entry[0].pos) + SW'(w_win)) <= SW'(r_item.pos);

    genvar gi;
    generate
        for (gi = 0; gi < QD; gi++) begin : g_cell
            logic   w_kp;
            logic   w_rv;
            t_entry w_re;
            if (gi == 0) begin : g_first
                assign w_kp = 1'b1;
            end else begin : g_mid
                assign w_kp = w_keep[gi-1];
            end
            if (gi == QD - 1) begin : g_last
                assign w_rv = (w_ctl.op == CELL_PUSH);
                assign w_re = r_item;
            end else begin : g_inner
                assign w_rv = w_valid[gi+1];
                assign w_re = w_entry[gi+1];
            end
            swm_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_new        (r_item),
                .i_keep_prev  (w_kp),
                .i_right_valid(w_rv),
                .i_right      (w_re),
                .o_valid      (w_valid[gi]),
                .o_entry      (w_entry[gi]),
                .o_keep       (w_keep[gi])
            );
        end
    endgenerate

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state    = r_state;
        w_ctl.op   = CELL_HOLD;
        w_ctl.full = w_keep[QD-1];
        w_load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_PUSH;
                    if (s_axis_tuser) begin
                        w_ctl.op = CELL_CLEAR;
                    end
                end
            end
            S_PUSH: begin
                w_ctl.op = CELL_PUSH;
                n_state  = S_EXPIRE;
            end
            S_EXPIRE: begin
                if (w_valid[0] && w_expired) begin
                    w_ctl.op = CELL_SHIFT;
                end else if (r_dropped) begin
                    n_state = S_DEDUP;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_DEDUP: begin
                if (w_valid[1] && (w_entry[0].hash == w_entry[1].hash)) begin
                    w_ctl.op = CELL_SHIFT;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state    = S_IDLE;
                    w_load_out = w_valid[0]
                              && (!r_emitted || (r_last_pos != w_entry[0].pos));
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_RESET;
            r_dropped   <= 1'b0;
            r_emitted   <= 1'b0;
            r_last_pos  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            if (r_state == S_PUSH) begin
                r_dropped <= 1'b0;
            end else if (r_state == S_EXPIRE && w_ctl.op == CELL_SHIFT) begin
                r_dropped <= 1'b1;
            end
            if (w_accept && s_axis_tuser) begin
                r_emitted  <= 1'b0;
                r_last_pos <= '0;
            end else if (w_load_out) begin
                r_emitted  <= 1'b1;
                r_last_pos <= w_entry[0].pos;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.kmer <= s_axis_tdata[K_LO +: CODE_W];
            r_item.hash <= s_axis_tdata[H_LO +: HASH_W];
            r_item.pos  <= s_axis_tdata[P_LO +: POS_W];
        end
        if (w_load_out) begin
            r_out_kmer <= w_entry[0].kmer;
            r_out_pos  <= w_entry[0].pos;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OPAD{1'b0}}, r_out_pos, r_out_kmer};

    `SWM_ASSERT_NOW(a_fill_contiguous, 1'b1, ((w_valid >> 1) & ~w_valid) == '0, "queue has a gap")
    `SWM_ASSERT_NOW(a_front_order, r_state == S_EMIT && w_valid[1], w_entry[0].hash <= w_entry[1].hash, "queue front out of hash order")
    `SWM_ASSERT_NOW(a_emit_nonempty, r_state == S_EMIT, w_valid[0], "queue empty at emit")
    `SWM_ASSERT_NEXT(a_emit_history, w_load_out, r_emitted && r_out_valid && (r_last_pos == r_out_pos), "emit history not updated")

endmodule
